>>> rtl/core/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define HHB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define HHB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/hhb_pkg.sv
// package with codes, constants and types of the hill-hold brake controller
`timescale 1ns / 1ps

package hhb_pkg;

    localparam int TIME_W  = 32;
    localparam int CFG_W   = 16;
    localparam int LEVEL_W = 10;
    localparam int GRAD_W  = 11;
    localparam int RAMP_W  = 16;

    localparam logic [1:0] MODE_OFF       = 2'd0;
    localparam logic [1:0] MODE_READY     = 2'd1;
    localparam logic [1:0] MODE_HOLDING   = 2'd2;
    localparam logic [1:0] MODE_RELEASING = 2'd3;

    localparam logic [1:0] REG_MIN_GRADIENT = 2'd0;
    localparam logic [1:0] REG_STOP_SPEED   = 2'd1;
    localparam logic [1:0] REG_MAX_HOLD     = 2'd2;
    localparam logic [1:0] REG_RAMP_TIME    = 2'd3;

    localparam logic [9:0]  BRAKE_ARM_LEVEL = 10'd50;
    localparam logic [9:0]  BRAKE_REL_LEVEL = 10'd20;
    localparam logic [9:0]  THROTTLE_LEVEL  = 10'd100;
    localparam logic [LEVEL_W-1:0] HOLD_FULL = 10'd800;

    localparam logic [9:0]  RST_MIN_GRADIENT = 10'd30;
    localparam logic [11:0] RST_STOP_SPEED   = 12'd10;
    localparam logic [15:0] RST_MAX_HOLD     = 16'd2000;
    localparam logic [15:0] RST_RAMP_TIME    = 16'd500;

    typedef struct packed {
        logic [TIME_W-1:0] d;
        logic              d_ge_max;
        logic              r_ge_ramp;
        logic [RAMP_W-1:0] ramp_diff;
    } t_ser_res;

endpackage

>>> rtl/core/hhb_serial_time.sv
// bit-serial time unit: elapsed time, ramp position and their compares
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hhb_serial_time (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [hhb_pkg::TIME_W-1:0] i_now,
    input  logic [hhb_pkg::TIME_W-1:0] i_start_time,
    input  logic [hhb_pkg::TIME_W-1:0] i_elapsed,
    input  logic [hhb_pkg::CFG_W-1:0]  i_max_hold,
    input  logic [hhb_pkg::RAMP_W-1:0] i_ramp,
    output hhb_pkg::t_ser_res          o_res,
    output logic                      o_done
);
    import hhb_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [4:0]        r_cnt;
    logic [TIME_W-1:0] r_sh_now;
    logic [TIME_W-1:0] r_sh_start;
    logic [TIME_W-1:0] r_sh_elap;
    logic [CFG_W-1:0]  r_sh_max;
    logic [RAMP_W-1:0] r_sh_ramp;
    logic [TIME_W-1:0] r_d;
    logic [RAMP_W-1:0] r_diff;
    logic              r_b1, r_b2, r_b3, r_b4, r_b5;

    logic a, s, e, m, t, d_bit, r_bit, q_bit;
    logic n_b1, n_b2, n_b3, n_b4, n_b5;

    always_comb begin
        a     = r_sh_now[0];
        s     = r_sh_start[0];
        e     = r_sh_elap[0];
        m     = r_sh_max[0];
        t     = r_sh_ramp[0];
        // d = now - start
        d_bit = a ^ s ^ r_b1;
        n_b1  = (~a & s) | (~(a ^ s) & r_b1);
        // r = d - elapsed
        r_bit = d_bit ^ e ^ r_b2;
        n_b2  = (~d_bit & e) | (~(d_bit ^ e) & r_b2);
        // borrow of d - max_hold
        n_b3  = (~d_bit & m) | (~(d_bit ^ m) & r_b3);
        // borrow of r - ramp
        n_b4  = (~r_bit & t) | (~(r_bit ^ t) & r_b4);
        // ramp - r
        q_bit = t ^ r_bit ^ r_b5;
        n_b5  = (~t & r_bit) | (~(t ^ r_bit) & r_b5);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sh_now   <= i_now;
            r_sh_start <= i_start_time;
            r_sh_elap  <= i_elapsed;
            r_sh_max   <= i_max_hold;
            r_sh_ramp  <= i_ramp;
            r_b1 <= 1'b0;
            r_b2 <= 1'b0;
            r_b3 <= 1'b0;
            r_b4 <= 1'b0;
            r_b5 <= 1'b0;
        end else if (r_busy) begin
            r_sh_now   <= {1'b0, r_sh_now[TIME_W-1:1]};
            r_sh_start <= {1'b0, r_sh_start[TIME_W-1:1]};
            r_sh_elap  <= {1'b0, r_sh_elap[TIME_W-1:1]};
            r_sh_max   <= {1'b0, r_sh_max[CFG_W-1:1]};
            r_sh_ramp  <= {1'b0, r_sh_ramp[RAMP_W-1:1]};
            r_b1 <= n_b1;
            r_b2 <= n_b2;
            r_b3 <= n_b3;
            r_b4 <= n_b4;
            r_b5 <= n_b5;
            r_d  <= {d_bit, r_d[TIME_W-1:1]};
            if (!r_cnt[4]) begin
                r_diff <= {q_bit, r_diff[RAMP_W-1:1]};
            end
        end
    end

    assign o_res.d         = r_d;
    assign o_res.d_ge_max  = ~r_b3;
    assign o_res.r_ge_ramp = ~r_b4;
    assign o_res.ramp_diff = r_diff;
    assign o_done          = r_done;

    `HHB_ASSERT_ALWAYS(a_no_done_after_reset, i_clk, (!i_rst_n) |=> !o_done, "done after reset")
    `HHB_ASSERT(a_done_ends_run, i_clk, i_rst_n, o_done |-> !r_busy, "done while still shifting")

endmodule

>>> rtl/core/hhb_ramp_div.sv
// iterative restoring divider for the release ramp level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hhb_ramp_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [hhb_pkg::RAMP_W-1:0]  i_x,
    input  logic [hhb_pkg::RAMP_W-1:0]  i_t,
    output logic [hhb_pkg::LEVEL_W-1:0] o_q,
    output logic                        o_done
);
    import hhb_pkg::*;

    localparam int NUM_W = RAMP_W + LEVEL_W;

    logic               r_busy;
    logic               r_done;
    logic [3:0]         r_cnt;
    logic [NUM_W-1:0]   r_rem;
    logic [NUM_W-1:0]   r_dvs;
    logic [LEVEL_W-1:0] r_q;
    logic [NUM_W-1:0]   num;
    logic               ge;

    // 800 * x as shifts and adds
    assign num = {1'b0, i_x, 9'b0} + {2'b0, i_x, 8'b0} + {5'b0, i_x, 5'b0};
    assign ge  = (r_rem >= r_dvs);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'(LEVEL_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= num;
            r_dvs <= {1'b0, i_t, 9'b0};
            r_q   <= '0;
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= r_rem - r_dvs;
            end
            r_dvs <= {1'b0, r_dvs[NUM_W-1:1]};
            r_q   <= {r_q[LEVEL_W-2:0], ge};
        end
    end

    assign o_q    = r_q;
    assign o_done = r_done;

    `HHB_ASSERT(a_level_in_range, i_clk, i_rst_n, (o_done && $past(r_busy)) |-> (o_q <= HOLD_FULL), "ramp level above full hold")

endmodule

>>> rtl/core/hill_hold_brake_controller.sv
// top level of the hill-hold brake controller: registers, mode logic, sequencing
// sequence: an accepted item runs the bit-serial time unit, then on a ramp step the divider,
// and is then committed to the state and the output registers
// a new item is taken only after the last one is committed; a waiting result holds the next commit
// reset (synchronous, active low) loads register defaults, mode off, control and mode state cleared
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hill_hold_brake_controller (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_idx,
    input  logic [hhb_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [hhb_pkg::GRAD_W-1:0] i_road_gradient,
    input  logic [9:0]                   i_brake_pedal,
    input  logic [9:0]                   i_throttle_pedal,
    input  logic [11:0]                  i_vehicle_speed,
    input  logic [1:0]                   i_gear_position,
    input  logic [hhb_pkg::TIME_W-1:0]   i_now_ms,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [1:0]                   o_mode,
    output logic [hhb_pkg::LEVEL_W-1:0]  o_hold_level,
    output logic [15:0]                  o_hold_span,
    output logic signed [hhb_pkg::GRAD_W-1:0] o_gradient_estimate
);
    import hhb_pkg::*;

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_SER  = 2'd1;
    localparam logic [1:0] C_DIV  = 2'd2;
    localparam logic [1:0] C_PUT  = 2'd3;

    logic [9:0]         r_min_grad;
    logic [11:0]        r_stop_speed;
    logic [15:0]        r_max_hold;
    logic [15:0]        r_ramp;

    logic [1:0]         r_mode, n_mode;
    logic               r_armed, n_armed;
    logic [TIME_W-1:0]  r_start_time, n_start_time;
    logic [TIME_W-1:0]  r_elapsed, n_elapsed;
    logic [GRAD_W-1:0]  r_lgrad, n_lgrad;
    logic [LEVEL_W-1:0] r_cmd, n_cmd;

    logic [GRAD_W-1:0]  r_grad;
    logic [9:0]         r_brake;
    logic [9:0]         r_throttle;
    logic [11:0]        r_speed;
    logic [1:0]         r_gear;
    logic [TIME_W-1:0]  r_now;

    logic [1:0]         r_ctl;
    logic               r_ovalid;
    logic [1:0]         r_omode;
    logic [LEVEL_W-1:0] r_olevel;
    logic [15:0]        r_odur;
    logic [GRAD_W-1:0]  r_ograd;

    logic               in_acc;
    logic               commit;
    logic               ser_done;
    t_ser_res           ser_res;
    logic               div_start;
    logic               div_done;
    logic [LEVEL_W-1:0] div_q;
    logic [GRAD_W-1:0]  mag;
    logic               armed_now;

    assign o_in_ready = (r_ctl == C_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign commit     = (r_ctl == C_PUT) && (!r_ovalid || i_out_ready);
    assign div_start  = (r_ctl == C_SER) && ser_done && (r_mode == MODE_RELEASING)
                        && !ser_res.r_ge_ramp;

    hhb_serial_time u_time (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (in_acc),
        .i_now        (i_now_ms),
        .i_start_time (r_start_time),
        .i_elapsed    (r_elapsed),
        .i_max_hold   (r_max_hold),
        .i_ramp       (r_ramp),
        .o_res        (ser_res),
        .o_done       (ser_done)
    );

    hhb_ramp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_x     (ser_res.ramp_diff),
        .i_t     (r_ramp),
        .o_q     (div_q),
        .o_done  (div_done)
    );

    // magnitude of gradient, most negative code maps to 1024
    assign mag = r_grad[GRAD_W-1] ? (~r_grad + 11'd1) : r_grad;

    always_comb begin
        n_mode       = r_mode;
        n_armed      = r_armed;
        n_start_time = r_start_time;
        n_elapsed    = r_elapsed;
        n_lgrad      = r_lgrad;
        n_cmd        = r_cmd;
        armed_now    = r_armed || (r_brake > BRAKE_ARM_LEVEL);
        case (r_mode)
            MODE_OFF: begin
                n_cmd = '0;
                if (mag >= {1'b0, r_min_grad}) begin
                    n_mode  = MODE_READY;
                    n_lgrad = r_grad;
                end
            end
            MODE_READY: begin
                n_cmd   = '0;
                n_lgrad = r_grad;
                if ({mag, 1'b0} < {2'b0, r_min_grad}) begin
                    n_mode = MODE_OFF;
                end else if (armed_now && (r_brake < BRAKE_REL_LEVEL)
                             && (r_speed < r_stop_speed) && r_gear[0]) begin
                    n_start_time = r_now;
                    n_elapsed    = '0;
                    n_cmd        = HOLD_FULL;
                    n_armed      = 1'b0;
                    n_mode       = MODE_HOLDING;
                end else begin
                    n_armed = armed_now;
                end
            end
            MODE_HOLDING: begin
                n_elapsed = ser_res.d;
                if ((r_throttle > THROTTLE_LEVEL) || ser_res.d_ge_max) begin
                    n_mode = MODE_RELEASING;
                end else begin
                    n_cmd = HOLD_FULL;
                end
            end
            default: begin
                if (ser_res.r_ge_ramp) begin
                    n_cmd  = '0;
                    n_mode = MODE_READY;
                end else begin
                    n_cmd = div_q;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_grad   <= RST_MIN_GRADIENT;
            r_stop_speed <= RST_STOP_SPEED;
            r_max_hold   <= RST_MAX_HOLD;
            r_ramp       <= RST_RAMP_TIME;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MIN_GRADIENT: r_min_grad   <= i_cfg_data[9:0];
                REG_STOP_SPEED:   r_stop_speed <= i_cfg_data[11:0];
                REG_MAX_HOLD:     r_max_hold   <= i_cfg_data;
                REG_RAMP_TIME:    r_ramp       <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl        <= C_IDLE;
            r_ovalid     <= 1'b0;
            r_mode       <= MODE_OFF;
            r_armed      <= 1'b0;
            r_start_time <= '0;
            r_elapsed    <= '0;
            r_lgrad      <= '0;
            r_cmd        <= '0;
        end else begin
            case (r_ctl)
                C_IDLE: begin
                    if (in_acc) begin
                        r_ctl <= C_SER;
                    end
                end
                C_SER: begin
                    if (ser_done) begin
                        r_ctl <= div_start ? C_DIV : C_PUT;
                    end
                end
                C_DIV: begin
                    if (div_done) begin
                        r_ctl <= C_PUT;
                    end
                end
                default: begin
                    if (commit) begin
                        r_ctl <= C_IDLE;
                    end
                end
            endcase
            if (commit) begin
                r_ovalid     <= 1'b1;
                r_mode       <= n_mode;
                r_armed      <= n_armed;
                r_start_time <= n_start_time;
                r_elapsed    <= n_elapsed;
                r_lgrad      <= n_lgrad;
                r_cmd        <= n_cmd;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_grad     <= i_road_gradient;
            r_brake    <= i_brake_pedal;
            r_throttle <= i_throttle_pedal;
            r_speed    <= i_vehicle_speed;
            r_gear     <= i_gear_position;
            r_now      <= i_now_ms;
        end
        if (commit) begin
            r_omode  <= n_mode;
            r_olevel <= n_cmd;
            r_odur   <= n_elapsed[15:0];
            r_ograd  <= n_lgrad;
        end
    end

    assign o_out_valid         = r_ovalid;
    assign o_mode              = r_omode;
    assign o_hold_level        = r_olevel;
    assign o_hold_span         = r_odur;
    assign o_gradient_estimate = r_ograd;

    `HHB_ASSERT(a_hold_is_full, i_clk, i_rst_n, (r_ovalid && (r_omode == MODE_HOLDING)) |-> (r_olevel == HOLD_FULL), "holding item without full level")
    `HHB_ASSERT(a_div_in_release, i_clk, i_rst_n, (r_ctl == C_DIV) |-> (r_mode == MODE_RELEASING), "divider run outside release")
    `HHB_ASSERT(a_put_waits, i_clk, i_rst_n, ((r_ctl == C_PUT) && r_ovalid && !i_out_ready) |=> (r_ctl == C_PUT), "result dropped while output stalled")

endmodule
